// ===== src/fbc_pkg.sv =====
// fbc_pkg: shared types and constants of the frustum box cull block
// no dependencies

package fbc_pkg;

  localparam int unsigned NUM_PLANES = 6;

  // plane whose coefficients depend on the depth mode
  localparam logic [2:0] PLANE_NEAR = 3'd4;

  // configuration register byte address
  localparam logic [1:0] ADDR_HOMOG_DEPTH = 2'd0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TEST,
    ST_DONE
  } state_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TEST = 1'b1
  } op_t;

  // controller to datapath
  typedef struct packed {
    logic       load;      // write matrix entry from input item
    logic       start;     // capture box for a test
    logic       plane_en;  // evaluate the selected plane this cycle
    logic [2:0] plane;
    logic       finish;    // update counters with the verdict
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic culled;
  } dp_sts_t;

endpackage

// ===== src/fbc_datapath.sv =====
// fbc_datapath: matrix store, plane evaluation and saturating counters
// depends on fbc_pkg

module fbc_datapath #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                homogeneous_depth,
  input  fbc_pkg::dp_cmd_t    cmd,
  output fbc_pkg::dp_sts_t    sts,
  input  logic [3:0]          matrix_index,
  input  logic signed [31:0]  matrix_value,
  input  logic signed [31:0]  box_min [3],
  input  logic signed [31:0]  box_max [3],
  input  logic [19:0]         first_instance,
  input  logic [15:0]         instance_count,
  output logic                visible,
  output logic [19:0]         range_start,
  output logic [15:0]         range_count,
  output logic [31:0]         chunks_drawn,
  output logic [31:0]         chunks_culled,
  output logic [31:0]         instances_drawn,
  output logic [31:0]         instances_culled
);

  localparam int AW = 68 + FRAC_BITS;

  logic signed [31:0] mat_r [16];
  logic signed [31:0] lo_r [3];
  logic signed [31:0] hi_r [3];
  logic [19:0] start_r;
  logic [15:0] count_r;
  logic culled_r;
  logic [31:0] cd_r, cc_r, id_r, ic_r;

  logic signed [32:0] coef [4];
  logic signed [31:0] sel [3];
  logic signed [64:0] prod [3];
  logic signed [AW-1:0] acc;
  logic [1:0] col;
  logic culled_now;

  always_comb begin
    col = cmd.plane[2:1];
    for (int k = 0; k < 4; k++) begin
      if (cmd.plane == fbc_pkg::PLANE_NEAR && !homogeneous_depth)
        coef[k] = 33'(mat_r[{2'(k), 2'd2}]);
      else if (cmd.plane[0])
        coef[k] = 33'(mat_r[{2'(k), 2'd3}]) - 33'(mat_r[{2'(k), col}]);
      else
        coef[k] = 33'(mat_r[{2'(k), 2'd3}]) + 33'(mat_r[{2'(k), col}]);
    end
    // positive vertex, full 65-bit products
    for (int k = 0; k < 3; k++) begin
      sel[k] = (coef[k] >= 0) ? hi_r[k] : lo_r[k];
      prod[k] = coef[k] * sel[k];
    end
    acc = (AW'(coef[3]) <<< FRAC_BITS) + AW'(prod[0]) + AW'(prod[1]) + AW'(prod[2]);
  end

  // verdict including the plane evaluated this cycle
  assign culled_now = culled_r | (cmd.plane_en & acc[AW-1]);
  assign sts.culled = culled_now;

  function automatic logic [31:0] sat_add(logic [31:0] c, logic [31:0] n);
    logic [32:0] s;
    s = {1'b0, c} + {1'b0, n};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      lo_r <= box_min;
      hi_r <= box_max;
      start_r <= first_instance;
      count_r <= instance_count;
    end
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) mat_r[i] <= '0;
      culled_r <= 1'b0;
      cd_r <= '0; cc_r <= '0; id_r <= '0; ic_r <= '0;
    end else begin
      if (cmd.load) mat_r[matrix_index] <= matrix_value;
      if (cmd.start) culled_r <= 1'b0;
      else if (cmd.plane_en && acc[AW-1]) culled_r <= 1'b1;
      if (cmd.load && matrix_index == 4'd0) begin
        cd_r <= '0; cc_r <= '0; id_r <= '0; ic_r <= '0;
      end
      if (cmd.finish) begin
        if (culled_now) begin
          cc_r <= sat_add(cc_r, 32'd1);
          ic_r <= sat_add(ic_r, 32'(count_r));
        end else begin
          cd_r <= sat_add(cd_r, 32'd1);
          id_r <= sat_add(id_r, 32'(count_r));
        end
      end
    end
  end

  assign visible = !culled_r;
  assign range_start = start_r;
  assign range_count = count_r;
  assign chunks_drawn = cd_r;
  assign chunks_culled = cc_r;
  assign instances_drawn = id_r;
  assign instances_culled = ic_r;

endmodule

// ===== src/fbc_ctrl.sv =====
// fbc_ctrl: sequencer stepping the six planes and the output handshake
// depends on fbc_pkg

module fbc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_op,
  output logic             out_valid,
  input  logic             out_ready,
  output fbc_pkg::dp_cmd_t cmd,
  input  fbc_pkg::dp_sts_t sts
);

  fbc_pkg::state_t state_r, state_nxt;
  logic [2:0] plane_r, plane_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fbc_pkg::ST_IDLE;
      plane_r <= '0;
    end else begin
      state_r <= state_nxt;
      plane_r <= plane_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    plane_nxt = plane_r;
    in_ready = 1'b0;
    out_valid = 1'b0;
    cmd = '0;
    cmd.plane = plane_r;
    unique case (state_r)
      fbc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_op == fbc_pkg::OP_LOAD) cmd.load = 1'b1;
          else begin
            cmd.start = 1'b1;
            plane_nxt = '0;
            state_nxt = fbc_pkg::ST_TEST;
          end
        end
      end
      fbc_pkg::ST_TEST: begin
        cmd.plane_en = 1'b1;
        plane_nxt = plane_r + 3'd1;
        // stop at the first plane the box lies behind
        if (plane_r == 3'(fbc_pkg::NUM_PLANES - 1) || sts.culled) begin
          cmd.finish = 1'b1;
          state_nxt = fbc_pkg::ST_DONE;
        end
      end
      fbc_pkg::ST_DONE: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = fbc_pkg::ST_IDLE;
      end
      default: state_nxt = fbc_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== src/frustum_box_cull.sv =====
// frustum_box_cull: top level of the view-frustum box culling block
// depends on fbc_pkg, fbc_ctrl, fbc_datapath

// A load item writes one Q16.16 matrix entry (entry 0 also clears the
// four counters). A test item captures the box when accepted, then steps
// one plane per cycle through a single shared plane evaluation unit
// (three 33x32 products and an exact wide sum), stopping at the first
// plane the box lies behind. The result is then offered and held until
// taken, and the next item is accepted the cycle after. The sign test is
// exact, with no rounding. The near plane is w+z when homogeneous_depth is
// set, else z alone.

module frustum_box_cull #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // operation
  input  logic         in_tuser,
  // matrix_index[3:0], matrix_value[35:4], box_min_x/y/z, box_max_x/y/z,
  // first_instance, instance_count (lowest bits first), no pad bits
  input  logic [263:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // visible, range_start, range_count, chunks_drawn, chunks_culled,
  // instances_drawn, instances_culled (lowest bits first), 3 zero pad bits
  output logic [167:0] out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [1:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  fbc_pkg::dp_cmd_t cmd;
  fbc_pkg::dp_sts_t sts;
  logic hdepth_r;
  logic signed [31:0] box_min [3];
  logic signed [31:0] box_max [3];
  logic visible;
  logic [19:0] range_start;
  logic [15:0] range_count;
  logic [31:0] cd, cc, id, ic;

  // config register, single register at address 0
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == fbc_pkg::ADDR_HOMOG_DEPTH) ? {31'd0, hdepth_r} : 32'd0;
  always_ff @(posedge clk) begin
    if (!rst_n) hdepth_r <= 1'b0;
    else if (cfg_psel && cfg_penable && cfg_pwrite &&
             cfg_paddr == fbc_pkg::ADDR_HOMOG_DEPTH)
      hdepth_r <= cfg_pwdata[0];
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      box_min[k] = in_tdata[36+32*k +: 32];
      box_max[k] = in_tdata[132+32*k +: 32];
    end
  end

  fbc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_tvalid), .in_ready(in_tready), .in_op(in_tuser),
    .out_valid(out_tvalid), .out_ready(out_tready), .cmd(cmd), .sts(sts)
  );

  fbc_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .homogeneous_depth(hdepth_r),
    .cmd(cmd), .sts(sts),
    .matrix_index(in_tdata[3:0]), .matrix_value(in_tdata[35:4]),
    .box_min(box_min), .box_max(box_max),
    .first_instance(in_tdata[247:228]), .instance_count(in_tdata[263:248]),
    .visible(visible), .range_start(range_start), .range_count(range_count),
    .chunks_drawn(cd), .chunks_culled(cc),
    .instances_drawn(id), .instances_culled(ic)
  );

  assign out_tdata = {3'd0, ic, id, cc, cd, range_count, range_start, visible};

endmodule
